>>> rtl/ntpa_pkg.sv
package ntpa_pkg;

   localparam int MaxTargets      = 256;
   localparam int AngleIterations = 16;
   localparam int CountW          = $clog2(MaxTargets + 1);
   localparam int IterW           = $clog2(AngleIterations + 1);

   typedef struct packed {
      logic               target_present;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [23:0] target_z;
      logic signed [23:0] observer_x;
      logic signed [23:0] observer_y;
      logic signed [23:0] observer_z;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         nearest_index;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic [27:0]        nearest_distance;
   } rsp_type;

   // Frame summary handed from the search front to the angle back end.
   typedef struct packed {
      logic               found;
      logic [7:0]         index;
      logic [51:0]        square;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [24:0] dz;
   } frame_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:  atan_turn = 32'h20000000;
         5'd1:  atan_turn = 32'h12E4051E;
         5'd2:  atan_turn = 32'h09FB385B;
         5'd3:  atan_turn = 32'h051111D4;
         5'd4:  atan_turn = 32'h028B0D43;
         5'd5:  atan_turn = 32'h0145D7E1;
         5'd6:  atan_turn = 32'h00A2F61E;
         5'd7:  atan_turn = 32'h00517C55;
         5'd8:  atan_turn = 32'h0028BE53;
         5'd9:  atan_turn = 32'h00145F2F;
         5'd10: atan_turn = 32'h000A2F98;
         5'd11: atan_turn = 32'h000517CC;
         5'd12: atan_turn = 32'h00028BE6;
         5'd13: atan_turn = 32'h000145F3;
         5'd14: atan_turn = 32'h0000A2FA;
         5'd15: atan_turn = 32'h0000517D;
         5'd16: atan_turn = 32'h000028BE;
         5'd17: atan_turn = 32'h0000145F;
         5'd18: atan_turn = 32'h00000A30;
         5'd19: atan_turn = 32'h00000518;
         5'd20: atan_turn = 32'h0000028C;
         5'd21: atan_turn = 32'h00000146;
         5'd22: atan_turn = 32'h000000A3;
         5'd23: atan_turn = 32'h00000051;
         default: atan_turn = 32'h0;
      endcase
   endfunction

endpackage

>>> rtl/nearest_target_pointing_angles_core.sv
// Finds the nearest target of each frame and reports its index, distance,
// yaw and pitch. Targets are taken one per cycle while the front is not stalled,
// through a two-stage compare pipeline; the item with frame_end yields one
// result. The frame's angle work then runs in a shared back end: a
// two-bit-per-step square root and a 16-step CORDIC, each run twice,
// overlapped with the next frame's targets through a two-entry queue.
// The search front stalls only when the queue and its summary register are full.
module nearest_target_pointing_angles_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntpa_pkg::rsp_type rsp_data
);
   import ntpa_pkg::*;

   logic      pitch_negate_ff;
   logic      f_valid, f_stall, q_valid, q_stall;
   frame_type f_data, q_data;

   // hold the config register
   always_ff @(posedge clock) begin
      if (reset)
         pitch_negate_ff <= 1'b1;
      else if (csr_write_enable)
         pitch_negate_ff <= csr_write_data;
   end

   ntpa_search u_search (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .frm_valid(f_valid), .frm_stall(f_stall), .frm_data(f_data)
   );

   ntpa_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   ntpa_angles u_angles (
      .clock(clock), .reset(reset), .pitch_negate(pitch_negate_ff),
      .frm_valid(q_valid), .frm_stall(q_stall), .frm_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // an empty frame reports all zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.nearest_index == 8'h0 &&
      rsp_data.nearest_distance == 28'h0)
      else $error("empty frame result not zero");

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // queue never presents data while reset just released
   a_queue_reset: assert property (@(posedge clock)
      $past(reset) |-> !q_valid)
      else $error("queue valid after reset");

endmodule

>>> rtl/ntpa_search.sv
// Front: per-target squared distance compare, one target per cycle when not stalled.
module ntpa_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntpa_pkg::req_type req_data,
   output logic                 frm_valid,
   input  logic                 frm_stall,
   output ntpa_pkg::frame_type  frm_data
);
   import ntpa_pkg::*;

   // stage 1: offsets and squares
   logic               s1_valid_ff;
   logic               s1_tgt_ff, s1_end_ff;
   logic signed [24:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [49:0]        s1_sx_ff, s1_sy_ff, s1_sz_ff;

   logic [51:0]        best_sq_ff;
   logic signed [24:0] best_dx_ff, best_dy_ff, best_dz_ff;
   logic [7:0]         best_pos_ff;
   logic [CountW-1:0]  seen_ff;
   logic               have_ff;

   logic               out_valid_ff;
   frame_type          out_ff;

   logic               adv;
   logic               take;
   logic signed [24:0] dx_in, dy_in, dz_in;
   logic [24:0]        ax, ay, az;
   logic [51:0]        sq_in;
   logic               better;

   // hold input while the summary register is full and the queue stalls it
   assign req_stall = out_valid_ff && frm_stall;
   assign adv       = req_valid && !req_stall;

   always_comb begin
      dx_in = 25'(req_data.target_x) - 25'(req_data.observer_x);
      dy_in = 25'(req_data.target_y) - 25'(req_data.observer_y);
      dz_in = 25'(req_data.target_z) - 25'(req_data.observer_z);
      ax    = dx_in[24] ? 25'(-dx_in) : dx_in;
      ay    = dy_in[24] ? 25'(-dy_in) : dy_in;
      az    = dz_in[24] ? 25'(-dz_in) : dz_in;
      sq_in = 52'(s1_sx_ff) + 52'(s1_sy_ff) + 52'(s1_sz_ff);
      take  = s1_valid_ff && s1_tgt_ff && (seen_ff < CountW'(MaxTargets));
      better = take && (sq_in < best_sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         best_sq_ff   <= '1;
         best_dx_ff   <= '0;
         best_dy_ff   <= '0;
         best_dz_ff   <= '0;
         best_pos_ff  <= '0;
         seen_ff      <= '0;
         have_ff      <= 1'b0;
      end else begin
         // pipeline advances only when not stalled
         if (!req_stall) begin
            s1_valid_ff <= adv && (req_data.target_present || req_data.frame_end);
            s1_tgt_ff   <= req_data.target_present;
            s1_end_ff   <= req_data.frame_end;
            s1_dx_ff    <= dx_in;
            s1_dy_ff    <= dy_in;
            s1_dz_ff    <= dz_in;
            s1_sx_ff    <= 50'(ax) * 50'(ax);
            s1_sy_ff    <= 50'(ay) * 50'(ay);
            s1_sz_ff    <= 50'(az) * 50'(az);
         end
         if (out_valid_ff && !frm_stall)
            out_valid_ff <= 1'b0;
         if (s1_valid_ff && !req_stall) begin
            if (s1_end_ff) begin
               // emit summary and clear frame
               out_valid_ff  <= 1'b1;
               out_ff.found  <= have_ff || better;
               out_ff.index  <= better ? seen_ff[7:0] : best_pos_ff;
               out_ff.square <= better ? sq_in : best_sq_ff;
               out_ff.dx     <= better ? s1_dx_ff : best_dx_ff;
               out_ff.dy     <= better ? s1_dy_ff : best_dy_ff;
               out_ff.dz     <= better ? s1_dz_ff : best_dz_ff;
               best_sq_ff  <= '1;
               best_dx_ff  <= '0;
               best_dy_ff  <= '0;
               best_dz_ff  <= '0;
               best_pos_ff <= '0;
               seen_ff     <= '0;
               have_ff     <= 1'b0;
            end else begin
               if (better) begin
                  best_sq_ff  <= sq_in;
                  best_dx_ff  <= s1_dx_ff;
                  best_dy_ff  <= s1_dy_ff;
                  best_dz_ff  <= s1_dz_ff;
                  best_pos_ff <= seen_ff[7:0];
                  have_ff     <= 1'b1;
               end
               if (take)
                  seen_ff <= seen_ff + 1'b1;
            end
         end
      end
   end

   assign frm_valid = out_valid_ff;
   assign frm_data  = out_ff;

endmodule

>>> rtl/ntpa_queue.sv
// Two-entry queue between search front and angle back end.
module ntpa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  ntpa_pkg::frame_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output ntpa_pkg::frame_type out_data
);
   import ntpa_pkg::*;

   frame_type  mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= in_data;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> rtl/ntpa_angles.sv
// Back: square roots and CORDIC angles, one step per cycle.
module ntpa_angles (
   input  logic                clock,
   input  logic                reset,
   input  logic                pitch_negate,
   input  logic                frm_valid,
   output logic                frm_stall,
   input  ntpa_pkg::frame_type frm_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ntpa_pkg::rsp_type   rsp_data
);
   import ntpa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HSQ, ST_SQRT, ST_YAW, ST_PITCH, ST_DONE
   } state_type;

   state_type          state_ff;
   frame_type          f_ff;
   // shared square root: 64-bit radicand, two bits per step
   logic [63:0]        rv_ff, rr_ff, rb_ff;
   logic               sqrt_h_ff;
   logic [27:0]        dist_ff;
   // shared CORDIC
   logic signed [35:0] cx_ff, cy_ff;
   logic [31:0]        acc_ff;
   logic [IterW-1:0]   it_ff;
   logic               zero_ff;
   logic [15:0]        yaw_ff;
   logic [15:0]        pitch_ff;
   logic [49:0]        hx_ff, hy_ff;
   logic               valid_ff;
   rsp_type            out_ff;

   logic [63:0]        rsum;
   logic signed [35:0] xs, ys;
   logic [31:0]        ang16;
   logic [15:0]        angle;
   logic [4:0]         it5;

   assign frm_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      rsum  = rr_ff + rb_ff;
      it5   = 5'(it_ff);
      xs    = cx_ff >>> it_ff;
      ys    = cy_ff >>> it_ff;
      ang16 = acc_ff + 32'h8000;
      angle = zero_ff ? 16'h0 : ang16[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && !rsp_stall)
            valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (frm_valid) begin
                  f_ff      <= frm_data;
                  hx_ff     <= 50'(frm_data.dx) * 50'(frm_data.dx);
                  hy_ff     <= 50'(frm_data.dy) * 50'(frm_data.dy);
                  rv_ff     <= 64'(frm_data.square);
                  rr_ff     <= '0;
                  rb_ff     <= 64'h1 << 62;
                  sqrt_h_ff <= 1'b0;
                  state_ff  <= frm_data.found ? ST_SQRT : ST_DONE;
               end
            end
            ST_HSQ: begin
               // horizontal length squared, scaled by 2^14
               rv_ff     <= 64'(64'(hx_ff) + 64'(hy_ff)) << 14;
               rr_ff     <= '0;
               rb_ff     <= 64'h1 << 62;
               sqrt_h_ff <= 1'b1;
               state_ff  <= ST_SQRT;
            end
            ST_SQRT: begin
               // advance one result bit
               if (rb_ff == '0) begin
                  if (sqrt_h_ff) begin
                     cx_ff   <= 36'(rr_ff);
                     cy_ff   <= 36'(f_ff.dz) <<< 7;
                     zero_ff <= (rr_ff == '0) && (f_ff.dz == '0);
                     acc_ff  <= '0;
                     it_ff   <= '0;
                     state_ff <= ST_PITCH;
                  end else begin
                     dist_ff <= rr_ff[27:0];
                     zero_ff <= (f_ff.dx == '0) && (f_ff.dy == '0);
                     it_ff   <= '0;
                     if (f_ff.dx[24]) begin
                        if (!f_ff.dy[24]) begin
                           cx_ff  <= 36'(f_ff.dy) <<< 7;
                           cy_ff  <= -(36'(f_ff.dx) <<< 7);
                           acc_ff <= 32'h40000000;
                        end else begin
                           cx_ff  <= -(36'(f_ff.dy) <<< 7);
                           cy_ff  <= 36'(f_ff.dx) <<< 7;
                           acc_ff <= 32'hC0000000;
                        end
                     end else begin
                        cx_ff  <= 36'(f_ff.dx) <<< 7;
                        cy_ff  <= 36'(f_ff.dy) <<< 7;
                        acc_ff <= '0;
                     end
                     state_ff <= ST_YAW;
                  end
               end else begin
                  if (rv_ff >= rsum) begin
                     rv_ff <= rv_ff - rsum;
                     rr_ff <= (rr_ff >> 1) + rb_ff;
                  end else begin
                     rr_ff <= rr_ff >> 1;
                  end
                  rb_ff <= rb_ff >> 2;
               end
            end
            ST_YAW, ST_PITCH: begin
               if (it_ff == IterW'(AngleIterations)) begin
                  if (state_ff == ST_YAW) begin
                     yaw_ff   <= angle;
                     state_ff <= ST_HSQ;
                  end else begin
                     state_ff <= ST_DONE;
                     f_ff.dz  <= '0;
                     yaw_ff   <= yaw_ff;
                     pitch_ff <= pitch_negate ? 16'(-angle) : angle;
                  end
               end else begin
                  // one rotation step
                  if (!cy_ff[35]) begin
                     cx_ff  <= cx_ff + ys;
                     cy_ff  <= cy_ff - xs;
                     acc_ff <= acc_ff + atan_turn(it5);
                  end else begin
                     cx_ff  <= cx_ff - ys;
                     cy_ff  <= cy_ff + xs;
                     acc_ff <= acc_ff - atan_turn(it5);
                  end
                  it_ff <= it_ff + 1'b1;
               end
            end
            ST_DONE: begin
               // wait for the output register to drain
               if (!valid_ff || !rsp_stall) begin
                  valid_ff <= 1'b1;
                  out_ff.found <= f_ff.found;
                  out_ff.nearest_index    <= f_ff.found ? f_ff.index : 8'h0;
                  out_ff.yaw_angle        <= f_ff.found ? yaw_ff : 16'h0;
                  out_ff.pitch_angle      <= f_ff.found ? pitch_ff : 16'h0;
                  out_ff.nearest_distance <= f_ff.found ? dist_ff : 28'h0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
